// ----- rtl/socu_pkg.sv -----
// ----------------------------------------------------------------------------
// socu_pkg
// shared constants, types and the arctangent table of the orbit coordinate unit
// ----------------------------------------------------------------------------
package socu_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int AB         = ANGLE_BITS;
  localparam int PW         = ((AB > 16) ? AB : 16) + 2;   // polar delta sum width
  localparam int CW         = 36;                          // cordic x/y width
  localparam int ZW         = 34;                          // cordic angle width
  localparam int MAW        = 34;                          // multiplier a operand
  localparam int MBW        = 32;                          // multiplier b operand
  localparam int PRW        = MAW + MBW;                   // product width
  localparam int STEPS      = 28;

  localparam logic [AB-1:0] ANG_HALF = AB'(1) << (AB - 1);
  localparam logic [30:0]   RAD_MAX  = 31'h7fff_ffff;
  localparam logic [CW-1:0] CORDIC_K30 = CW'(652032874);

  localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SQR   = 11'b000_0000_0010,
    S_ROOT  = 11'b000_0000_0100,
    S_VLOAD = 11'b000_0000_1000,
    S_NORM  = 11'b000_0001_0000,
    S_ROT   = 11'b000_0010_0000,
    S_VFIN  = 11'b000_0100_0000,
    S_TLOAD = 11'b000_1000_0000,
    S_TFIN  = 11'b001_0000_0000,
    S_MUL   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = ZW'(536870912);
      5'd1:  v = ZW'(316933406);
      5'd2:  v = ZW'(167458907);
      5'd3:  v = ZW'(85004756);
      5'd4:  v = ZW'(42667331);
      5'd5:  v = ZW'(21354465);
      5'd6:  v = ZW'(10679838);
      5'd7:  v = ZW'(5340245);
      5'd8:  v = ZW'(2670163);
      5'd9:  v = ZW'(1335087);
      5'd10: v = ZW'(667544);
      5'd11: v = ZW'(333772);
      5'd12: v = ZW'(166886);
      5'd13: v = ZW'(83443);
      5'd14: v = ZW'(41722);
      5'd15: v = ZW'(20861);
      5'd16: v = ZW'(10430);
      5'd17: v = ZW'(5215);
      5'd18: v = ZW'(2608);
      5'd19: v = ZW'(1304);
      5'd20: v = ZW'(652);
      5'd21: v = ZW'(326);
      5'd22: v = ZW'(163);
      5'd23: v = ZW'(81);
      5'd24: v = ZW'(41);
      5'd25: v = ZW'(20);
      5'd26: v = ZW'(10);
      5'd27: v = ZW'(5);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/spherical_orbit_coordinate_unit.sv -----
// ----------------------------------------------------------------------------
// spherical_orbit_coordinate_unit
// spherical position register with delta update, cartesian load and
// cartesian (y-up) readout
// ----------------------------------------------------------------------------
// channel  | ports                                          | dir
// in       | in_valid/in_ready, in_kind, in_d_*, in_x/y/z   | request in
// out      | out_valid/out_ready, out_x/y/z, out_cur_*      | result out
//
// one request at a time; in_ready is high only in idle
// delta request: two 28-step rotation passes, then four rounded products from the multiplier
// load request: 3 squares, two 32-step square roots,
//   two vectoring passes of a prescale and 28 steps each, then the delta path
// one shared cordic stage serves all passes, the one 34x32 multiplier all products
// rst_n (synchronous) clears the position to zero and the sequencer to idle
// a result held by out_ready low just waits in the output registers
module spherical_orbit_coordinate_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_d_radius,
  input  logic signed [15:0] in_d_theta,
  input  logic signed [15:0] in_d_phi,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic        [30:0] out_cur_radius,
  output logic        [15:0] out_cur_polar,
  output logic        [15:0] out_cur_azimuth
);

  localparam int AB  = socu_pkg::AB;
  localparam int CW  = socu_pkg::CW;
  localparam int ZW  = socu_pkg::ZW;
  localparam int PW  = socu_pkg::PW;
  localparam int MAW = socu_pkg::MAW;
  localparam int MBW = socu_pkg::MBW;
  localparam int PRW = socu_pkg::PRW;

  socu_pkg::state_t state_r, state_nxt;

  // position state
  logic [30:0]   rad_r, rad_nxt;
  logic [AB-1:0] pol_r, pol_nxt;
  logic [AB-1:0] azi_r, azi_nxt;

  // latched load vector
  logic signed [31:0] lx_r, lx_nxt, ly_r, ly_nxt, lz_r, lz_nxt;

  // sums of squares and square roots
  logic [63:0] acc_r, acc_nxt, accxy_r, accxy_nxt;
  logic [63:0] sv_r, sv_nxt, sres_r, sres_nxt;
  logic [4:0]  sk_r, sk_nxt;
  logic [31:0] rho_r, rho_nxt, rr_r, rr_nxt;

  // shared cordic stage
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt;
  logic [4:0]           ci_r, ci_nxt;
  logic                 vec_r, vec_nxt;     // vectoring when set, rotation otherwise
  logic                 sel_r, sel_nxt;     // polar/theta pass when low, azimuth/phi when high
  logic                 sqsel_r, sqsel_nxt; // xy root when low, full root when high
  logic                 xneg_r, xneg_nxt;
  logic [1:0]           q_r, q_nxt;

  // trig results
  logic signed [ZW-1:0] st_r, st_nxt, ct_r, ct_nxt, sp_r, sp_nxt, cp_r, cp_nxt;
  logic signed [ZW-1:0] fnum_r, fnum_nxt;

  // shared multiplier
  logic [2:0]     cnt_r, cnt_nxt;
  logic [MAW-1:0] ma;
  logic [MBW-1:0] mb;
  logic           mneg;
  logic [PRW-1:0] prod_r;
  logic           pneg_r;

  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;

  function automatic logic [MAW-1:0] mag34(input logic signed [ZW-1:0] v);
    logic signed [ZW-1:0] n;
    n = -v;
    return v[ZW-1] ? MAW'(n) : MAW'(v);
  endfunction

  function automatic logic [MBW-1:0] mag32(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // round(|p| / 2^30) half away from zero, sign applied afterwards
  logic [PRW-30:0]   rq;
  logic signed [ZW-1:0] rsigned;
  logic signed [31:0]   rsat;
  always_comb begin
    logic [PRW:0] t;
    t  = {1'b0, prod_r} + (PRW + 1)'(1 << 29);
    rq = t[PRW:30];
    rsigned = pneg_r ? -ZW'(rq) : ZW'(rq);
    if (!pneg_r && (rq > (PRW - 29)'(32'h7fff_ffff)))
      rsat = 32'sh7fff_ffff;
    else if (pneg_r && (rq > (PRW - 29)'(33'h0_8000_0000)))
      rsat = 32'sh8000_0000;
    else
      rsat = 32'(rsigned);
  end

  // multiplier operand selection
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    if (state_r == socu_pkg::S_SQR) begin
      case (cnt_r)
        3'd0:    begin ma = MAW'(mag32(33'(lx_r))); mb = mag32(33'(lx_r)); end
        3'd1:    begin ma = MAW'(mag32(33'(ly_r))); mb = mag32(33'(ly_r)); end
        default: begin ma = MAW'(mag32(33'(lz_r))); mb = mag32(33'(lz_r)); end
      endcase
    end else begin
      case (cnt_r)
        3'd0:    begin ma = MAW'(rad_r); mb = MBW'(mag34(st_r)); mneg = st_r[ZW-1]; end
        3'd1:    begin ma = MAW'(rad_r); mb = MBW'(mag34(ct_r)); mneg = ct_r[ZW-1]; end
        3'd2:    begin
          ma = mag34(fnum_r); mb = MBW'(mag34(cp_r)); mneg = fnum_r[ZW-1] ^ cp_r[ZW-1];
        end
        default: begin
          ma = mag34(fnum_r); mb = MBW'(mag34(sp_r)); mneg = fnum_r[ZW-1] ^ sp_r[ZW-1];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PRW'(ma) * PRW'(mb);
    pneg_r <= mneg;
  end

  // square root step, one result bit per cycle
  logic [63:0] sbit;
  logic [64:0] strial;
  logic        sfit;
  logic [63:0] sres_step, sv_step;
  always_comb begin
    sbit      = 64'(1) << {sk_r, 1'b0};
    strial    = {1'b0, sres_r} + {1'b0, sbit};
    sfit      = {1'b0, sv_r} >= strial;
    sv_step   = sfit ? (sv_r - strial[63:0]) : sv_r;
    sres_step = sfit ? ((sres_r >> 1) + sbit) : (sres_r >> 1);
  end

  // cordic micro-rotation
  logic signed [CW-1:0] xs, ys, x_step, y_step, aby;
  logic signed [ZW-1:0] at, z_step;
  logic                 pos, big;
  always_comb begin
    xs  = cx_r >>> ci_r;
    ys  = cy_r >>> ci_r;
    at  = $signed(socu_pkg::atan_lut(ci_r));
    pos = vec_r ? cy_r[CW-1] : !cz_r[ZW-1];
    x_step = pos ? (cx_r - ys) : (cx_r + ys);
    y_step = pos ? (cy_r + xs) : (cy_r - xs);
    z_step = pos ? (cz_r - at) : (cz_r + at);
    aby = cy_r[CW-1] ? -cy_r : cy_r;
    big = (cx_r[CW-1:32] != '0) || (aby[CW-1:32] != '0);
  end

  // polar angle from the vectoring result
  logic [AB-1:0] pol_fin;
  always_comb begin
    logic signed [ZW:0] p;
    logic [32:0]        pc;
    logic [33:0]        pr;
    p = $signed((ZW + 1)'(1 << 30)) - (ZW + 1)'(cz_r);
    if (p[ZW])
      pc = '0;
    else if (p > $signed((ZW + 1)'(33'h0_8000_0000)))
      pc = 33'h0_8000_0000;
    else
      pc = p[32:0];
    pr = ({1'b0, pc} + 34'(34'd1 << (31 - AB))) >> (32 - AB);
    pol_fin = (pr > 34'(socu_pkg::ANG_HALF)) ? socu_pkg::ANG_HALF : pr[AB-1:0];
  end

  // azimuth from the vectoring result
  logic [AB-1:0] azi_fin;
  always_comb begin
    logic [31:0] a32;
    a32 = cz_r[31:0] + (xneg_r ? 32'h8000_0000 : 32'h0) + 32'(32'd1 << (31 - AB));
    azi_fin = a32[31 -: AB];
  end

  // trig pass setup: quadrant fold to +-1/8 turn
  logic [31:0] ta32, tqs, trem;
  logic [1:0]  tq;
  always_comb begin
    ta32 = {(sel_r ? azi_r : pol_r), {(32 - AB){1'b0}}};
    tqs  = ta32 + 32'h2000_0000;
    tq   = tqs[31:30];
    trem = ta32 - {tq, 30'b0};
  end

  // delta update
  logic signed [33:0]   nr;
  logic signed [PW-1:0] np;
  logic [30:0]          nr_c;
  logic [AB-1:0]        np_c;
  always_comb begin
    nr = $signed({3'b000, rad_r}) + 34'(in_d_radius);
    np = $signed(PW'({1'b0, pol_r})) + PW'(in_d_theta);
    if (nr[33])
      nr_c = '0;
    else if (nr > $signed({3'b000, socu_pkg::RAD_MAX}))
      nr_c = socu_pkg::RAD_MAX;
    else
      nr_c = nr[30:0];
    if (np[PW-1])
      np_c = '0;
    else if (np > $signed(PW'(socu_pkg::ANG_HALF)))
      np_c = socu_pkg::ANG_HALF;
    else
      np_c = np[AB-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rad_nxt = rad_r;  pol_nxt = pol_r;  azi_nxt = azi_r;
    lx_nxt = lx_r;  ly_nxt = ly_r;  lz_nxt = lz_r;
    acc_nxt = acc_r;  accxy_nxt = accxy_r;
    sv_nxt = sv_r;  sres_nxt = sres_r;  sk_nxt = sk_r;
    rho_nxt = rho_r;  rr_nxt = rr_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;  ci_nxt = ci_r;
    vec_nxt = vec_r;  sel_nxt = sel_r;  sqsel_nxt = sqsel_r;
    xneg_nxt = xneg_r;  q_nxt = q_r;
    st_nxt = st_r;  ct_nxt = ct_r;  sp_nxt = sp_r;  cp_nxt = cp_r;
    fnum_nxt = fnum_r;  cnt_nxt = cnt_r;
    ox_nxt = ox_r;  oy_nxt = oy_r;  oz_nxt = oz_r;

    case (state_r)
      socu_pkg::S_IDLE: begin
        if (in_valid) begin
          sel_nxt = 1'b0;
          cnt_nxt = '0;
          if (in_kind) begin
            lx_nxt = in_x;
            ly_nxt = in_y;
            lz_nxt = in_z;
            state_nxt = socu_pkg::S_SQR;
          end else begin
            rad_nxt = nr_c;
            pol_nxt = np_c;
            azi_nxt = azi_r + AB'(in_d_phi);
            state_nxt = socu_pkg::S_TLOAD;
          end
        end
      end

      // x*x, y*y, z*z through the multiplier, each summed from the registered product
      socu_pkg::S_SQR: begin
        cnt_nxt = cnt_r + 3'd1;
        case (cnt_r)
          3'd0: ;
          3'd1: acc_nxt = prod_r[63:0];
          3'd2: begin
            acc_nxt   = acc_r + prod_r[63:0];
            accxy_nxt = acc_r + prod_r[63:0];
          end
          default: begin
            acc_nxt   = acc_r + prod_r[63:0];
            sv_nxt    = accxy_r;
            sres_nxt  = '0;
            sk_nxt    = 5'd31;
            sqsel_nxt = 1'b0;
            state_nxt = socu_pkg::S_ROOT;
          end
        endcase
      end

      socu_pkg::S_ROOT: begin
        sv_nxt   = sv_step;
        sres_nxt = sres_step;
        sk_nxt   = sk_r - 5'd1;
        if (sk_r == '0) begin
          if (!sqsel_r) begin
            rho_nxt   = sres_step[31:0];
            sv_nxt    = acc_r;
            sres_nxt  = '0;
            sk_nxt    = 5'd31;
            sqsel_nxt = 1'b1;
          end else begin
            rr_nxt    = sres_step[31:0];
            sel_nxt   = 1'b0;
            state_nxt = socu_pkg::S_VLOAD;
          end
        end
      end

      socu_pkg::S_VLOAD: begin
        vec_nxt = 1'b1;
        cz_nxt  = '0;
        if (!sel_r) begin
          rad_nxt = rr_r[31] ? socu_pkg::RAD_MAX : rr_r[30:0];
          if (rr_r == '0) begin
            pol_nxt = '0;
            sel_nxt = 1'b1;
          end else begin
            cx_nxt = CW'({1'b0, rho_r});
            cy_nxt = CW'(lz_r);
            state_nxt = socu_pkg::S_NORM;
          end
        end else begin
          if (rho_r == '0) begin
            azi_nxt   = '0;
            sel_nxt   = 1'b0;
            state_nxt = socu_pkg::S_TLOAD;
          end else begin
            xneg_nxt = lx_r[31];
            cx_nxt   = lx_r[31] ? -CW'(lx_r) : CW'(lx_r);
            cy_nxt   = lx_r[31] ? -CW'(ly_r) : CW'(ly_r);
            state_nxt = socu_pkg::S_NORM;
          end
        end
      end

      // scale the vector up until its larger part reaches 2^32
      socu_pkg::S_NORM: begin
        if (big) begin
          ci_nxt    = '0;
          state_nxt = socu_pkg::S_ROT;
        end else begin
          cx_nxt = cx_r <<< 1;
          cy_nxt = cy_r <<< 1;
        end
      end

      socu_pkg::S_ROT: begin
        cx_nxt = x_step;
        cy_nxt = y_step;
        cz_nxt = z_step;
        ci_nxt = ci_r + 5'd1;
        if (ci_r == socu_pkg::LAST_STEP)
          state_nxt = vec_r ? socu_pkg::S_VFIN : socu_pkg::S_TFIN;
      end

      socu_pkg::S_VFIN: begin
        if (!sel_r) begin
          pol_nxt   = pol_fin;
          sel_nxt   = 1'b1;
          state_nxt = socu_pkg::S_VLOAD;
        end else begin
          azi_nxt   = azi_fin;
          sel_nxt   = 1'b0;
          state_nxt = socu_pkg::S_TLOAD;
        end
      end

      socu_pkg::S_TLOAD: begin
        vec_nxt = 1'b0;
        q_nxt   = tq;
        cx_nxt  = socu_pkg::CORDIC_K30;
        cy_nxt  = '0;
        cz_nxt  = ZW'($signed(trem));
        ci_nxt  = '0;
        state_nxt = socu_pkg::S_ROT;
      end

      // undo the quadrant fold
      socu_pkg::S_TFIN: begin
        logic signed [ZW-1:0] c, s;
        case (q_r)
          2'd0:    begin c = ZW'(cx_r);  s = ZW'(cy_r);  end
          2'd1:    begin c = -ZW'(cy_r); s = ZW'(cx_r);  end
          2'd2:    begin c = -ZW'(cx_r); s = -ZW'(cy_r); end
          default: begin c = ZW'(cy_r);  s = -ZW'(cx_r); end
        endcase
        if (!sel_r) begin
          st_nxt  = s;
          ct_nxt  = c;
          sel_nxt = 1'b1;
          state_nxt = socu_pkg::S_TLOAD;
        end else begin
          sp_nxt  = s;
          cp_nxt  = c;
          cnt_nxt = '0;
          state_nxt = socu_pkg::S_MUL;
        end
      end

      // r*st, r*ct, fnum*cp, fnum*sp, each rounded from the registered product
      socu_pkg::S_MUL: begin
        cnt_nxt = cnt_r + 3'd1;
        case (cnt_r)
          3'd0: ;
          3'd1: fnum_nxt = rsigned;
          3'd2: oy_nxt = rsat;
          3'd3: ox_nxt = rsat;
          default: begin
            oz_nxt    = rsat;
            state_nxt = socu_pkg::S_DONE;
          end
        endcase
      end

      socu_pkg::S_DONE: begin
        if (out_ready)
          state_nxt = socu_pkg::S_IDLE;
      end

      default: state_nxt = socu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= socu_pkg::S_IDLE;
      rad_r   <= '0;
      pol_r   <= '0;
      azi_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rad_r   <= rad_nxt;
      pol_r   <= pol_nxt;
      azi_r   <= azi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lx_r <= lx_nxt;  ly_r <= ly_nxt;  lz_r <= lz_nxt;
    acc_r <= acc_nxt;  accxy_r <= accxy_nxt;
    sv_r <= sv_nxt;  sres_r <= sres_nxt;  sk_r <= sk_nxt;
    rho_r <= rho_nxt;  rr_r <= rr_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;  ci_r <= ci_nxt;
    vec_r <= vec_nxt;  sel_r <= sel_nxt;  sqsel_r <= sqsel_nxt;
    xneg_r <= xneg_nxt;  q_r <= q_nxt;
    st_r <= st_nxt;  ct_r <= ct_nxt;  sp_r <= sp_nxt;  cp_r <= cp_nxt;
    fnum_r <= fnum_nxt;  cnt_r <= cnt_nxt;
    ox_r <= ox_nxt;  oy_r <= oy_nxt;  oz_r <= oz_nxt;
  end

  assign in_ready        = (state_r == socu_pkg::S_IDLE);
  assign out_valid       = (state_r == socu_pkg::S_DONE);
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_cur_radius  = rad_r;
  assign out_cur_polar   = 16'(pol_r);
  assign out_cur_azimuth = 16'(azi_r);

endmodule

// ----- rtl/socu_checker.sv -----
// ----------------------------------------------------------------------------
// socu_checker
// port-level checks of the orbit coordinate unit
// ----------------------------------------------------------------------------
module socu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic signed [31:0] in_d_radius,
  input logic signed [15:0] in_d_theta,
  input logic signed [15:0] in_d_phi,
  input logic signed [31:0] in_x,
  input logic signed [31:0] in_y,
  input logic signed [31:0] in_z,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic        [30:0] out_cur_radius,
  input logic        [15:0] out_cur_polar,
  input logic        [15:0] out_cur_azimuth
);

  // one request in flight: never ready while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // a result never shows the cycle after a request is taken
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

  // a taken result is not repeated
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_cur_radius)) else $error("result changed");

  // polar angle stays within half a turn
  a_polar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (socu_pkg::ANGLE_BITS > 16) ||
      (32'(out_cur_polar) <= 32'(socu_pkg::ANG_HALF))) else $error("polar out of range");

endmodule

bind spherical_orbit_coordinate_unit socu_checker u_socu_checker (.*);

// ----- dv/tb_spherical_orbit_coordinate_unit.sv -----
// ----------------------------------------------------------------------------
// tb_spherical_orbit_coordinate_unit
// self-checking bench: fixed-point spherical position model predicts the
// cartesian readout of every request, randomized valid/ready idling
// ----------------------------------------------------------------------------
module tb_spherical_orbit_coordinate_unit;

  localparam int     ANGLE_BITS = socu_pkg::ANGLE_BITS;
  localparam longint RADMAX = 64'h7fff_ffff;
  localparam longint AFULL  = 64'd1 << ANGLE_BITS;
  localparam longint AHALF  = 64'd1 << (ANGLE_BITS - 1);

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [30:0] radius;
    logic [15:0] polar, azim;
  } orbit_pos_t;

  // ---------------------------------------------------------------------
  // fixed point orbit predictor and store of expected positions
  // ---------------------------------------------------------------------
  class orbit_scoreboard;
    longint rad, pol, azm;
    orbit_pos_t pending[$];
    int errors;
    int seen;
    longint atab[28];

    function new();
      atab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
               10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
               83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
               41, 20, 10, 5};
      rad = 0; pol = 0; azm = 0; errors = 0; seen = 0;
    endfunction

    // >>> on longint is arithmetic, i.e. floor shift
    function longint isqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0; bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else res >>= 1;
        bit_w >>= 2;
      end
      return longint'(res);
    endfunction

    function longint mulq30(longint a, longint b);
      bit neg;
      longint unsigned ua, ub, q;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      q = (ua * ub + (64'd1 << 29)) >> 30;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    task sincos(input logic [31:0] a, output longint s, output longint c);
      logic [31:0] q, rr;
      longint z, x, y, t;
      q = ((a + (32'd1 << 29)) >> 30) & 32'd3;
      rr = a - (q << 30);
      z = rr;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      x = 652032874; y = 0;
      for (int i = 0; i < 28; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atab[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atab[i];
        end
      end
      case (q)
        0: begin c = x; s = y; end
        1: begin c = -y; s = x; end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endtask

    function longint atan_right(longint y, longint x);
      longint z, t, my;
      z = 0;
      forever begin
        my = y < 0 ? -y : y;
        if ((x > my ? x : my) >= 64'sd4294967296) break;
        x *= 2; y *= 2;
      end
      for (int i = 0; i < 28; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atab[i];
        end else begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atab[i];
        end
      end
      return z;
    endfunction

    function void load_cart(longint x, longint y, longint z);
      longint unsigned xx, yy, zz, r;
      longint rho, p;
      longint unsigned pr;
      logic [31:0] a32;
      xx = x * x; yy = y * y; zz = z * z;
      r = isqrt(xx + yy + zz);
      rho = isqrt(xx + yy);
      rad = (r > RADMAX) ? RADMAX : r;
      if (r == 0) pol = 0;
      else begin
        p = (64'sd1 << 30) - atan_right(z, rho);
        if (p < 0) p = 0;
        if (p > (64'sd1 << 31)) p = 64'sd1 << 31;
        pr = (p + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        pol = (pr > AHALF) ? AHALF : pr;
      end
      if (rho == 0) azm = 0;
      else begin
        if (x < 0) a32 = 32'(atan_right(-y, -x) + (64'sd1 << 31));
        else a32 = 32'(atan_right(y, x));
        a32 += 32'd1 << (31 - ANGLE_BITS);
        azm = (a32 >> (32 - ANGLE_BITS)) & (AFULL - 1);
      end
    endfunction

    // note an accepted request and queue the position it leads to
    task note_request(input logic kind, input logic signed [31:0] dr,
                      input logic signed [15:0] dt, input logic signed [15:0] dp,
                      input logic signed [31:0] x, input logic signed [31:0] y,
                      input logic signed [31:0] z);
      longint nr, np, st, ct, sp, cp, fnum;
      orbit_pos_t e;
      if (kind == 1'b0) begin
        nr = rad + longint'(dr);
        np = pol + longint'(dt);
        if (nr < 0) nr = 0;
        if (nr > RADMAX) nr = RADMAX;
        if (np < 0) np = 0;
        if (np > AHALF) np = AHALF;
        rad = nr; pol = np;
        azm = (azm + longint'(dp)) & (AFULL - 1);
      end else load_cart(x, y, z);
      sincos(32'(pol << (32 - ANGLE_BITS)), st, ct);
      sincos(32'(azm << (32 - ANGLE_BITS)), sp, cp);
      fnum = mulq30(rad, st);
      e.x = 32'(sat32(mulq30(fnum, cp)));
      e.y = 32'(sat32(mulq30(rad, ct)));
      e.z = 32'(sat32(mulq30(fnum, sp)));
      e.radius = 31'(rad);
      e.polar = 16'(pol);
      e.azim = 16'(azm);
      pending.push_back(e);
    endtask

    function void check_result(orbit_pos_t a);
      orbit_pos_t e;
      seen++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin $error("out_x exp %0d got %0d", e.x, a.x); errors++; end
      if (a.y !== e.y) begin $error("out_y exp %0d got %0d", e.y, a.y); errors++; end
      if (a.z !== e.z) begin $error("out_z exp %0d got %0d", e.z, a.z); errors++; end
      if (a.radius !== e.radius) begin
        $error("out_cur_radius exp %0h got %0h", e.radius, a.radius); errors++;
      end
      if (a.polar !== e.polar) begin
        $error("out_cur_polar exp %0d got %0d", e.polar, a.polar); errors++;
      end
      if (a.azim !== e.azim) begin
        $error("out_cur_azimuth exp %0d got %0d", e.azim, a.azim); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, in_kind = 1'b0;
  logic signed [31:0] in_d_radius = '0, in_x = '0, in_y = '0, in_z = '0;
  logic signed [15:0] in_d_theta = '0, in_d_phi = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [30:0] out_cur_radius;
  logic [15:0] out_cur_polar, out_cur_azimuth;

  orbit_scoreboard sb = new();
  bit calm;        // no idling in the tail of the run
  int n_loads, n_adjusts;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  spherical_orbit_coordinate_unit dut (.*);

  // result side: random ready bursts, check on every accepted result
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        orbit_pos_t a;
        a.x = out_x; a.y = out_y; a.z = out_z;
        a.radius = out_cur_radius; a.polar = out_cur_polar; a.azim = out_cur_azimuth;
        sb.check_result(a);
      end
    end
  end

  // drive one request, holding it until accepted; valid stays up afterwards
  // so that back-to-back requests need no second assignment in one step
  task send_request(input logic kind, input logic signed [31:0] dr,
                    input logic signed [15:0] dt, input logic signed [15:0] dp,
                    input logic signed [31:0] x, input logic signed [31:0] y,
                    input logic signed [31:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind; in_d_radius <= dr; in_d_theta <= dt; in_d_phi <= dp;
    in_x <= x; in_y <= y; in_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(kind, dr, dt, dp, x, y, z);
    if (kind) n_loads++; else n_adjusts++;
  endtask

  task adjust(input logic signed [31:0] dr, input logic signed [15:0] dt,
              input logic signed [15:0] dp);
    send_request(1'b0, dr, dt, dp, 32'($urandom), 32'($urandom), 32'($urandom));
  endtask

  task load(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic signed [31:0] z);
    send_request(1'b1, 32'($urandom), 16'($urandom), 16'($urandom), x, y, z);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'($urandom);
      1: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return '0;
      default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dr();
    case ($urandom_range(0, 3))
      0: return 32'($urandom);
      1: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, clamps, wrap, zero vectors, axis signs
    adjust(32'sh0001_0000, 16'sd0, 16'sd0);
    adjust(-32'sh8000_0000, 16'sd0, 16'sd0);        // radius clamps at zero
    adjust(32'sh7fff_ffff, 16'sd8192, 16'sd100);
    adjust(32'sh7fff_ffff, 16'sh7fff, -16'sh8000);  // radius saturates, polar to pi
    adjust(32'sd0, -16'sh8000, 16'sh7fff);          // polar drops exactly to zero
    adjust(32'sd0, 16'sd16384, 16'sd32767);
    adjust(32'sd0, 16'sd0, 16'sd2);
    adjust(-32'sh4000_0000, 16'sd1234, -16'sd5000);
    load(32'sd0, 32'sd0, 32'sd0);                   // zero vector
    load(32'sd0, 32'sd0, 32'sh0001_0000);           // zero xy length
    load(32'sd0, 32'sd0, -32'sh0001_0000);
    load(-32'sh0001_0000, 32'sd0, 32'sd0);          // azimuth is pi
    load(32'sh0001_0000, 32'sd0, 32'sd0);
    load(32'sd0, 32'sh0001_0000, 32'sd0);
    load(32'sd0, -32'sh0001_0000, 32'sd0);
    load(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);  // long vector
    load(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    load(32'sd1, -32'sd1, 32'sd1);
    load(-32'sd3, 32'sd5, -32'sd7);
    load(32'sh0123_4567, -32'sh0765_4321, 32'sh0011_2233);
    adjust(32'sh0000_8000, 16'sd100, -16'sd100);
    in_valid <= 1'b0;

    // hold off until every outstanding result has come back
    while (sb.pending.size() != 0) @(posedge clk);

    // random: mostly walks of adjusts with occasional loads
    for (int i = 0; i < 1880; i++) begin
      if (i == 1780) calm = 1'b1;
      if ($urandom_range(0, 3) == 0)
        load(rand_coord(), rand_coord(), rand_coord());
      else if ($urandom_range(0, 9) == 0)
        adjust(32'($urandom), 16'($urandom), 16'($urandom));
      else
        adjust(rand_dr(), 16'(int'($urandom_range(0, 8000)) - 4000),
               16'(int'($urandom_range(0, 16000)) - 8000));
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("covered %0d adjust and %0d load requests, %0d results checked",
             n_adjusts, n_loads, sb.seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("spherical_orbit_coordinate_unit regression: pass");
    else
      $display("spherical_orbit_coordinate_unit regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("spherical_orbit_coordinate_unit regression: fail");
    $finish;
  end

endmodule
